FILE: rtl/ehc_pkg.sv
// ----------------------------------------------------------------------------
// ehc_pkg
// Shared types and constants of the expiring hash cache.
// ----------------------------------------------------------------------------
`default_nettype none

package ehc_pkg;

  localparam int unsigned DEF_TABLE_SIZE   = 256;
  localparam int unsigned DEF_RECORD_BYTES = 16;
  localparam int unsigned HASH_W           = 64;
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned HALF_W           = 64;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_GET   = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_PURGE = 2'd2
  } walk_mode_t;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_HASH  = 10'b00_0000_0100,
    S_HEAD  = 10'b00_0000_1000,
    S_LOOK  = 10'b00_0001_0000,
    S_EVAL  = 10'b00_0010_0000,
    S_PREV  = 10'b00_0100_0000,
    S_FRESH = 10'b00_1000_0000,
    S_LINK  = 10'b01_0000_0000,
    S_RESP  = 10'b10_0000_0000
  } state_t;

  // write strobes toward the two memories
  typedef struct packed {
    logic bkt_we;
    logic ent_we;
  } store_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/ehc_if.sv
// ----------------------------------------------------------------------------
// ehc_if
// Request and response channels of the expiring hash cache.
// ----------------------------------------------------------------------------
`default_nettype none

interface ehc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] key_hash;
  logic [63:0] value_low;
  logic [63:0] value_high;
  logic [31:0] expiry_time;
  logic [31:0] current_time;

  modport source (
    output valid, op, key_hash, value_low, value_high, expiry_time, current_time,
    input  ready
  );
  modport sink (
    input  valid, op, key_hash, value_low, value_high, expiry_time, current_time,
    output ready
  );
endinterface

interface ehc_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [63:0] found_low;
  logic [63:0] found_high;

  modport source (output valid, ok, found_low, found_high, input ready);
  modport sink   (input valid, ok, found_low, found_high, output ready);
endinterface

`default_nettype wire

FILE: rtl/ehc_bucket_calc.sv
// ----------------------------------------------------------------------------
// ehc_bucket_calc
// Reduces the 64-bit key hash modulo the table size to a bucket number.
// ----------------------------------------------------------------------------
`default_nettype none

module ehc_bucket_calc #(
  parameter int unsigned TABLE_SIZE = ehc_pkg::DEF_TABLE_SIZE
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ehc_pkg::HASH_W-1:0]    hash,
  output logic                               done,
  output logic [$clog2(TABLE_SIZE)-1:0]      bucket
);

  localparam int unsigned AW   = $clog2(TABLE_SIZE);
  localparam bit          POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          bucket <= hash[AW-1:0];
        end
      end
    end else begin : g_fold
      localparam logic [AW:0] NV = (AW+1)'(TABLE_SIZE);

      function automatic int unsigned pow2_mod(int unsigned k);
        int unsigned r;
        r = 1;
        for (int unsigned i = 0; i < k; i++) begin
          r = 2 * r;
          if (r >= TABLE_SIZE) begin
            r = r - TABLE_SIZE;
          end
        end
        return r;
      endfunction

      function automatic logic [AW-1:0] mod_add(logic [AW-1:0] a, logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= NV) ? AW'(s - NV) : s[AW-1:0];
      endfunction

      logic [AW-1:0]              pw   [ehc_pkg::HASH_W];
      logic [AW-1:0]              term [8];
      logic [AW-1:0]              s01, s23, s45, s67, s03, s47, s07;
      logic [AW-1:0]              acc;
      logic [ehc_pkg::HASH_W-1:0] sh;
      logic [2:0]                 cnt;
      logic                       busy;

      // weight of every hash bit position: 2^k mod size
      for (genvar k = 0; k < ehc_pkg::HASH_W; k++) begin : g_pw
        assign pw[k] = AW'(pow2_mod(k));
      end

      // one hash byte a cycle, lsb first, summed modulo size in a small tree
      for (genvar j = 0; j < 8; j++) begin : g_term
        assign term[j] = sh[j] ? pw[{cnt, 3'(j)}] : '0;
      end

      assign s01    = mod_add(term[0], term[1]);
      assign s23    = mod_add(term[2], term[3]);
      assign s45    = mod_add(term[4], term[5]);
      assign s67    = mod_add(term[6], term[7]);
      assign s03    = mod_add(s01, s23);
      assign s47    = mod_add(s45, s67);
      assign s07    = mod_add(s03, s47);
      assign bucket = acc;

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
        end else begin
          done <= busy && !start && cnt == 3'd7;
          if (start) begin
            busy <= 1'b1;
          end else if (busy && cnt == 3'd7) begin
            busy <= 1'b0;
          end
        end
        if (start) begin
          acc <= '0;
          sh  <= hash;
          cnt <= '0;
        end else if (busy) begin
          acc <= mod_add(acc, s07);
          sh  <= sh >> 8;
          cnt <= cnt + 3'd1;
        end
      end
    end
  endgenerate

endmodule

`default_nettype wire

FILE: rtl/ehc_store.sv
// ----------------------------------------------------------------------------
// ehc_store
// Bucket head memory and entry memory, one write and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none

module ehc_store #(
  parameter int unsigned TABLE_SIZE   = ehc_pkg::DEF_TABLE_SIZE,
  parameter int unsigned RECORD_BYTES = ehc_pkg::DEF_RECORD_BYTES
) (
  input  wire logic                                 clk,
  input  wire ehc_pkg::store_ctl_t                  ctl,
  input  wire logic [$clog2(TABLE_SIZE)-1:0]        bkt_waddr,
  input  wire logic [$clog2(TABLE_SIZE+1)-1:0]      bkt_wdata,
  input  wire logic [$clog2(TABLE_SIZE)-1:0]        bkt_raddr,
  output logic [$clog2(TABLE_SIZE+1)-1:0]           bkt_rdata,
  input  wire logic [$clog2(TABLE_SIZE)-1:0]        ent_waddr,
  input  wire logic [$clog2(TABLE_SIZE+1)-1:0]      ent_wlink,
  input  wire logic [ehc_pkg::HASH_W-1:0]           ent_whash,
  input  wire logic [ehc_pkg::TIME_W-1:0]           ent_wexp,
  input  wire logic [8*RECORD_BYTES-1:0]            ent_wval,
  input  wire logic [$clog2(TABLE_SIZE)-1:0]        ent_raddr,
  output logic [$clog2(TABLE_SIZE+1)-1:0]           ent_rlink,
  output logic [ehc_pkg::HASH_W-1:0]                ent_rhash,
  output logic [ehc_pkg::TIME_W-1:0]                ent_rexp,
  output logic [8*RECORD_BYTES-1:0]                 ent_rval
);

  localparam int unsigned LW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned VW = 8 * RECORD_BYTES;

  logic [LW-1:0]              bkt_mem  [TABLE_SIZE];
  logic [LW-1:0]              link_mem [TABLE_SIZE];
  logic [ehc_pkg::HASH_W-1:0] hash_mem [TABLE_SIZE];
  logic [ehc_pkg::TIME_W-1:0] exp_mem  [TABLE_SIZE];
  logic [VW-1:0]              val_mem  [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (ctl.bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rdata <= bkt_mem[bkt_raddr];
  end

  // the entry fields share one address and are written as one word
  always_ff @(posedge clk) begin
    if (ctl.ent_we) begin
      link_mem[ent_waddr] <= ent_wlink;
      hash_mem[ent_waddr] <= ent_whash;
      exp_mem[ent_waddr]  <= ent_wexp;
      val_mem[ent_waddr]  <= ent_wval;
    end
    ent_rlink <= link_mem[ent_raddr];
    ent_rhash <= hash_mem[ent_raddr];
    ent_rexp  <= exp_mem[ent_raddr];
    ent_rval  <= val_mem[ent_raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/expiring_hash_cache.sv
// ----------------------------------------------------------------------------
// expiring_hash_cache
// Hash-keyed value cache with per-entry expiry, chained buckets, free list.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every entry of both
// memories and takes no request until it ends. A request is then accepted,
// its key hash is reduced to a bucket (a mask for a power-of-two table size,
// a byte-wise fold otherwise), the bucket head is fetched, and each chain
// entry visited is read through the registered entry memory and evaluated;
// an expired entry unlinked behind a kept predecessor also passes through
// the predecessor update, and the response is handed over last. A get walks
// its chain once; a put walks it twice (live check, then purge) and then
// takes and links the free entry, unless the check finds a live match or
// the free list is empty. The chain walk in the entry memory sets the rate;
// one request is in work at a time while a finished response may still
// wait on the output.
`default_nettype none

module expiring_hash_cache #(
  parameter int unsigned TABLE_SIZE   = ehc_pkg::DEF_TABLE_SIZE,
  parameter int unsigned RECORD_BYTES = ehc_pkg::DEF_RECORD_BYTES
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ehc_req_if.sink    req,
  ehc_rsp_if.source  rsp
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned LW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned VW = 8 * RECORD_BYTES;
  localparam logic [LW-1:0] NIL = LW'(TABLE_SIZE);

  ehc_pkg::state_t     state, state_next;
  ehc_pkg::walk_mode_t mode;

  logic                        op_q;
  logic [ehc_pkg::HASH_W-1:0]  hash_q;
  logic [VW-1:0]               val_q;
  logic [ehc_pkg::TIME_W-1:0]  exp_q;
  logic [ehc_pkg::TIME_W-1:0]  now_q;
  logic [LW-1:0]               head;
  logic [LW-1:0]               cur;
  logic [LW-1:0]               prev;
  logic [ehc_pkg::HASH_W-1:0]  prev_hash;
  logic [ehc_pkg::TIME_W-1:0]  prev_exp;
  logic [VW-1:0]               prev_val;
  logic [AW-1:0]               fresh;
  logic [LW-1:0]               free_head;
  logic [AW-1:0]               clr_idx;
  logic                        res_ok;
  logic [VW-1:0]               res_val;
  logic                        out_valid;
  logic                        out_ok;
  logic [2*ehc_pkg::HALF_W-1:0] out_found;

  logic                        calc_start;
  logic                        calc_done;
  logic [AW-1:0]               bucket;

  ehc_pkg::store_ctl_t         ctl;
  logic [AW-1:0]               bkt_waddr;
  logic [LW-1:0]               bkt_wdata;
  logic [LW-1:0]               bkt_rdata;
  logic [AW-1:0]               ent_waddr;
  logic [AW-1:0]               ent_raddr;
  logic [LW-1:0]               ent_wlink;
  logic [ehc_pkg::HASH_W-1:0]  ent_whash;
  logic [ehc_pkg::TIME_W-1:0]  ent_wexp;
  logic [VW-1:0]               ent_wval;
  logic [LW-1:0]               ent_rlink;
  logic [ehc_pkg::HASH_W-1:0]  ent_rhash;
  logic [ehc_pkg::TIME_W-1:0]  ent_rexp;
  logic [VW-1:0]               ent_rval;

  logic cur_ok;
  logic expired;
  logic hmatch;
  logic live;
  logic release_now;
  logic accept;
  logic [2*ehc_pkg::HALF_W-1:0] value_in;

  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == ehc_pkg::S_IDLE);
  assign calc_start  = accept;
  assign cur_ok      = cur < NIL;
  assign expired     = ent_rexp < now_q;
  assign hmatch      = ent_rhash == hash_q;
  assign live        = ent_rexp > now_q;
  assign value_in    = {req.value_high, req.value_low};
  assign release_now = (mode == ehc_pkg::MODE_GET   && expired) ||
                       (mode == ehc_pkg::MODE_PURGE && (hmatch || expired));

  assign rsp.valid      = out_valid;
  assign rsp.ok         = out_ok;
  assign rsp.found_low  = out_found[ehc_pkg::HALF_W-1:0];
  assign rsp.found_high = out_found[2*ehc_pkg::HALF_W-1:ehc_pkg::HALF_W];

  ehc_bucket_calc #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_calc (
    .clk    (clk),
    .rst    (rst),
    .start  (calc_start),
    .hash   (req.key_hash),
    .done   (calc_done),
    .bucket (bucket)
  );

  ehc_store #(
    .TABLE_SIZE   (TABLE_SIZE),
    .RECORD_BYTES (RECORD_BYTES)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .bkt_waddr (bkt_waddr),
    .bkt_wdata (bkt_wdata),
    .bkt_raddr (bucket),
    .bkt_rdata (bkt_rdata),
    .ent_waddr (ent_waddr),
    .ent_wlink (ent_wlink),
    .ent_whash (ent_whash),
    .ent_wexp  (ent_wexp),
    .ent_wval  (ent_wval),
    .ent_raddr (ent_raddr),
    .ent_rlink (ent_rlink),
    .ent_rhash (ent_rhash),
    .ent_rexp  (ent_rexp),
    .ent_rval  (ent_rval)
  );

  // walk reads the current entry; at the end of the live check the free head
  assign ent_raddr = cur_ok ? cur[AW-1:0] : free_head[AW-1:0];

  always_comb begin
    ctl        = '0;
    bkt_waddr  = bucket;
    bkt_wdata  = NIL;
    ent_waddr  = cur[AW-1:0];
    ent_wlink  = free_head;
    ent_whash  = ent_rhash;
    ent_wexp   = '0;
    ent_wval   = ent_rval;
    state_next = state;
    case (state)
      ehc_pkg::S_CLEAR: begin
        ctl.bkt_we = 1'b1;
        ctl.ent_we = 1'b1;
        bkt_waddr  = clr_idx;
        ent_waddr  = clr_idx;
        ent_wlink  = LW'(clr_idx) + LW'(1);
        ent_whash  = '0;
        ent_wval   = '0;
        if (clr_idx == AW'(TABLE_SIZE - 1)) begin
          state_next = ehc_pkg::S_IDLE;
        end
      end
      ehc_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ehc_pkg::S_HASH;
        end
      end
      ehc_pkg::S_HASH: begin
        if (calc_done) begin
          if (op_q == ehc_pkg::OP_PUT && free_head == NIL) begin
            state_next = ehc_pkg::S_RESP;
          end else begin
            state_next = ehc_pkg::S_HEAD;
          end
        end
      end
      ehc_pkg::S_HEAD: begin
        state_next = ehc_pkg::S_LOOK;
      end
      ehc_pkg::S_LOOK: begin
        if (cur_ok) begin
          state_next = ehc_pkg::S_EVAL;
        end else begin
          case (mode)
            ehc_pkg::MODE_CHECK: state_next = ehc_pkg::S_FRESH;
            ehc_pkg::MODE_PURGE: state_next = ehc_pkg::S_LINK;
            default:             state_next = ehc_pkg::S_RESP;
          endcase
        end
      end
      ehc_pkg::S_EVAL: begin
        if (release_now) begin
          ctl.ent_we = 1'b1;
          if (prev == NIL) begin
            ctl.bkt_we = 1'b1;
            bkt_wdata  = ent_rlink;
            state_next = ehc_pkg::S_LOOK;
          end else begin
            state_next = ehc_pkg::S_PREV;
          end
        end else if ((mode == ehc_pkg::MODE_GET && hmatch) ||
                     (mode == ehc_pkg::MODE_CHECK && hmatch && live)) begin
          state_next = ehc_pkg::S_RESP;
        end else begin
          state_next = ehc_pkg::S_LOOK;
        end
      end
      ehc_pkg::S_PREV: begin
        // predecessor now skips the released entry
        ctl.ent_we = 1'b1;
        ent_waddr  = prev[AW-1:0];
        ent_wlink  = cur;
        ent_whash  = prev_hash;
        ent_wexp   = prev_exp;
        ent_wval   = prev_val;
        state_next = ehc_pkg::S_LOOK;
      end
      ehc_pkg::S_FRESH: begin
        state_next = ehc_pkg::S_LOOK;
      end
      ehc_pkg::S_LINK: begin
        ctl.ent_we = 1'b1;
        ctl.bkt_we = 1'b1;
        ent_waddr  = fresh;
        ent_wlink  = head;
        ent_whash  = hash_q;
        ent_wexp   = exp_q;
        ent_wval   = val_q;
        bkt_wdata  = LW'(fresh);
        state_next = ehc_pkg::S_RESP;
      end
      ehc_pkg::S_RESP: begin
        if (!out_valid || rsp.ready) begin
          state_next = ehc_pkg::S_IDLE;
        end
      end
      default: state_next = ehc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ehc_pkg::S_CLEAR;
      clr_idx   <= '0;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ehc_pkg::S_RESP && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ehc_pkg::S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
        end
        ehc_pkg::S_EVAL: begin
          if (release_now) begin
            free_head <= cur;
          end
        end
        ehc_pkg::S_FRESH: begin
          free_head <= ent_rlink;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ehc_pkg::S_IDLE: begin
        op_q    <= req.op;
        hash_q  <= req.key_hash;
        val_q   <= value_in[VW-1:0];
        exp_q   <= req.expiry_time;
        now_q   <= req.current_time;
        res_ok  <= 1'b0;
        res_val <= '0;
        mode    <= (req.op == ehc_pkg::OP_PUT) ? ehc_pkg::MODE_CHECK : ehc_pkg::MODE_GET;
      end
      ehc_pkg::S_HEAD: begin
        head <= bkt_rdata;
        cur  <= bkt_rdata;
        prev <= NIL;
      end
      ehc_pkg::S_EVAL: begin
        cur <= ent_rlink;
        if (release_now) begin
          if (prev == NIL) begin
            head <= ent_rlink;
          end else begin
            prev_hash <= prev_hash;
          end
        end else if (mode == ehc_pkg::MODE_GET && hmatch) begin
          res_ok  <= 1'b1;
          res_val <= ent_rval;
        end else if (mode == ehc_pkg::MODE_CHECK && hmatch && live) begin
          res_ok <= 1'b1;
        end else if (mode != ehc_pkg::MODE_CHECK) begin
          prev      <= cur;
          prev_hash <= ent_rhash;
          prev_exp  <= ent_rexp;
          prev_val  <= ent_rval;
        end
      end
      ehc_pkg::S_FRESH: begin
        fresh <= free_head[AW-1:0];
        mode  <= ehc_pkg::MODE_PURGE;
        cur   <= head;
        prev  <= NIL;
      end
      ehc_pkg::S_LINK: begin
        res_ok <= 1'b1;
      end
      ehc_pkg::S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_ok    <= res_ok;
          out_found <= (2*ehc_pkg::HALF_W)'(res_val);
        end
      end
      default: ;
    endcase
  end

  a_rsp_from_resp : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ehc_pkg::S_RESP))
    else $error("response raised outside the response state");

  a_free_head_range : assert property (@(posedge clk) disable iff (rst)
    free_head <= NIL)
    else $error("free list head out of range");

  a_purge_not_fresh : assert property (@(posedge clk) disable iff (rst)
    (state == ehc_pkg::S_EVAL && mode == ehc_pkg::MODE_PURGE) |-> cur[AW-1:0] != fresh)
    else $error("purge walk reached the entry being inserted");

  a_put_full : assert property (@(posedge clk) disable iff (rst)
    (state == ehc_pkg::S_HASH && calc_done && op_q == ehc_pkg::OP_PUT && free_head == NIL)
    |=> (state == ehc_pkg::S_RESP && !res_ok))
    else $error("put on empty free list not refused");

endmodule

`default_nettype wire
